>>> hw/rtl/adcmv_pkg.sv
// ----------------------------------------------------------------------------
// adcmv_pkg - shared types and constants of the millivolt display
// Sequencer states, scaling constants, segment decode and BCD step.
// ----------------------------------------------------------------------------
package adcmv_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam int SMP_W  = 10;   // ADC sample width
    localparam int FS_W   = 14;   // full scale width
    localparam int ACC_W  = 24;   // product 1023 * 9999 fits
    localparam int Q_W    = 14;   // quotient up to 9999
    localparam int REM_W  = 10;   // remainder below 1023
    localparam int BCD_DIGITS = 4;
    localparam int BCD_W  = 4 * BCD_DIGITS;
    localparam int CNT_W  = 4;

    localparam logic [REM_W:0]  ADC_FULL = 11'd1023;
    localparam logic [FS_W-1:0] MV_CAP   = 14'd9999;
    localparam logic [FS_W-1:0] FS_RESET = 14'd5000;

    localparam logic [CNT_W-1:0] MUL_LAST = 4'd9;   // SMP_W - 1
    localparam logic [CNT_W-1:0] DIV_LAST = 4'd13;  // Q_W - 1

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_DP    = 8'h80;

    function automatic logic [7:0] seg_decode(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // one double-dabble step: add 3 to digits of five and up, then shift in
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] b,
                                                     input logic            din);
        logic [BCD_W-1:0] a;
        a = b;
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (a[4*k +: 4] >= 4'd5)
            begin
                a[4*k +: 4] = a[4*k +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], din};
    endfunction

endpackage

>>> hw/rtl/adc_millivolt_seven_segment_display.sv
// ----------------------------------------------------------------------------
// adc_millivolt_seven_segment_display - ADC voltmeter with muxed 7-seg drive
// A sample is scaled to millivolts, split into decimal digits and held; a
// scan tick moves the lit position. Every input transaction returns one drive word.
// ----------------------------------------------------------------------------
// Usage: an input transaction is either a 10-bit ADC sample (operation 0) or
// a scan tick (operation 1), and each yields exactly one output transaction:
// a one-hot digit_enable plus the segment pattern of the digit at the current
// position, decimal point lit on position 0. A sample is shown as
// floor(sample * full_scale_mv / 1023) with leading zeros, full_scale_mv
// capped at 9999 on write. A sample runs a bit-serial shift-add multiply
// (ST_MUL), then restoring division by 1023 (ST_DIV) whose quotient bits
// feed a double-dabble BCD converter in the same cycle, then ST_DONE loads
// the output register. A tick goes straight to ST_DONE. in_ready is high
// only with the sequencer idle; a finished result waits in the output
// register while the next input transaction is accepted, and ST_DONE holds
// until that register is free. Configuration is taken at any time
// but must only be written while the block is idle.
// ----------------------------------------------------------------------------
module adc_millivolt_seven_segment_display #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] full_scale_mv,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [9:0]  sample,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  digit_enable,
    output logic [7:0]  segments
);

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

    adcmv_pkg::state_t state_reg, state_next;

    logic [adcmv_pkg::FS_W-1:0]  fs_reg, fs_next;
    logic [adcmv_pkg::SMP_W-1:0] smp_reg, smp_next;
    logic [adcmv_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [adcmv_pkg::BCD_W-1:0] bcd_reg, bcd_next;
    logic [adcmv_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [3:0]                  digits_reg [DIGIT_COUNT];
    logic [3:0]                  digits_next [DIGIT_COUNT];
    logic [3:0]                  store_digits [DIGIT_COUNT];

    logic                        out_valid_reg, out_valid_next;
    logic [3:0]                  de_reg, de_next;
    logic [7:0]                  seg_reg, seg_next;

    // division step signals
    logic [adcmv_pkg::REM_W:0]   div_trial;
    logic                        q_bit;
    logic [adcmv_pkg::REM_W:0]   div_diff;
    logic [adcmv_pkg::REM_W-1:0] div_rem;
    logic [adcmv_pkg::BCD_W-1:0] bcd_step;

    logic in_fire;
    logic out_free;
    logic [3:0] cur_digit;
    logic [3:0] de_cur;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == adcmv_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign digit_enable = de_reg;
    assign segments     = seg_reg;

    // restoring division by 1023: remainder lives in acc[23:14], dividend
    // bits shift out of acc[13:0] MSB first
    assign div_trial = {acc_reg[adcmv_pkg::ACC_W-1:adcmv_pkg::Q_W],
                        acc_reg[adcmv_pkg::Q_W-1]};
    assign q_bit     = (div_trial >= adcmv_pkg::ADC_FULL);
    assign div_diff  = div_trial - adcmv_pkg::ADC_FULL;
    assign div_rem   = q_bit ? div_diff[adcmv_pkg::REM_W-1:0]
                             : div_trial[adcmv_pkg::REM_W-1:0];
    assign bcd_step  = adcmv_pkg::dabble_step(bcd_reg, q_bit);

    // most significant digit at position 0; low-order digits kept when
    // there are fewer positions, leading zeros when there are more
    for (genvar k = 0; k < DIGIT_COUNT; k++)
    begin : g_store
        if (DIGIT_COUNT - 1 - k < adcmv_pkg::BCD_DIGITS)
        begin : g_bcd
            assign store_digits[k] = bcd_step[4*(DIGIT_COUNT-1-k) +: 4];
        end
        else
        begin : g_zero
            assign store_digits[k] = 4'd0;
        end
    end

    assign cur_digit = digits_reg[pos_reg];

    always_comb
    begin
        de_cur = 4'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (int'(pos_reg) == k)
            begin
                de_cur[k] = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            adcmv_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (operation == adcmv_pkg::OP_TICK) ? adcmv_pkg::ST_DONE
                                                                  : adcmv_pkg::ST_MUL;
                end
            end
            adcmv_pkg::ST_MUL:
            begin
                if (cnt_reg == adcmv_pkg::MUL_LAST)
                begin
                    state_next = adcmv_pkg::ST_DIV;
                end
            end
            adcmv_pkg::ST_DIV:
            begin
                if (cnt_reg == adcmv_pkg::DIV_LAST)
                begin
                    state_next = adcmv_pkg::ST_DONE;
                end
            end
            adcmv_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = adcmv_pkg::ST_IDLE;
                end
            end
            default: state_next = adcmv_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fs_next        = fs_reg;
        smp_next       = smp_reg;
        acc_next       = acc_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        digits_next    = digits_reg;
        out_valid_next = out_valid_reg && !out_ready;
        de_next        = de_reg;
        seg_next       = seg_reg;

        if (cfg_valid)
        begin
            fs_next = (full_scale_mv > adcmv_pkg::MV_CAP) ? adcmv_pkg::MV_CAP
                                                          : full_scale_mv;
        end

        case (state_reg)
            adcmv_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    smp_next = sample;
                    acc_next = '0;
                    bcd_next = '0;
                    cnt_next = '0;
                    if (operation == adcmv_pkg::OP_TICK)
                    begin
                        pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                    end
                end
            end
            adcmv_pkg::ST_MUL:
            begin
                // MSB-first shift-add
                acc_next = {acc_reg[adcmv_pkg::ACC_W-2:0], 1'b0}
                         + (smp_reg[adcmv_pkg::SMP_W-1]
                            ? adcmv_pkg::ACC_W'(fs_reg) : '0);
                smp_next = {smp_reg[adcmv_pkg::SMP_W-2:0], 1'b0};
                cnt_next = (cnt_reg == adcmv_pkg::MUL_LAST) ? '0 : cnt_reg + 1'b1;
            end
            adcmv_pkg::ST_DIV:
            begin
                acc_next = {div_rem, acc_reg[adcmv_pkg::Q_W-2:0], 1'b0};
                bcd_next = bcd_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == adcmv_pkg::DIV_LAST)
                begin
                    digits_next = store_digits;
                end
            end
            adcmv_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    de_next        = de_cur;
                    seg_next       = adcmv_pkg::seg_decode(cur_digit)
                                   | ((pos_reg == '0) ? adcmv_pkg::SEG_DP
                                                      : adcmv_pkg::SEG_BLANK);
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adcmv_pkg::ST_IDLE;
            fs_reg        <= adcmv_pkg::FS_RESET;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DIGIT_COUNT; k++)
            begin
                digits_reg[k] <= 4'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fs_reg        <= fs_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            digits_reg    <= digits_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        acc_reg <= acc_next;
        bcd_reg <= bcd_next;
        de_reg  <= de_next;
        seg_reg <= seg_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < DIGIT_COUNT)
        else $error("scan position beyond last digit");

    a_de_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(digit_enable))
        else $error("digit enable not one-hot");

    a_dp_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (segments[7] == digit_enable[0]))
        else $error("decimal point not tied to leftmost position");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation == adcmv_pkg::OP_SAMPLE) |=>
            (state_reg == adcmv_pkg::ST_MUL && cnt_reg == '0))
        else $error("sample transaction did not start the multiply");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == adcmv_pkg::ST_DIV) |-> (cnt_reg <= adcmv_pkg::DIV_LAST))
        else $error("division step count overrun");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the ADC millivolt seven-segment display
// A queue-fed driver sends sample and tick transactions under several idle
// and stall patterns, with full-scale settings written between phases.
// Every accepted input transaction is run through a local model of the
// display, and the monitor checks each drive word against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_DIGITS     = 4;
    localparam int CLK_HALF       = 6;      // 12 ns period
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 40;     // comfortably above the sample path
    localparam int STALL_LIMIT    = 2000;   // cycles without any transaction
    localparam int PHASE_ITEMS    = 228;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_REPORTS    = 10;

    // idle patterns, one per phase in rotation
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    // segment patterns for 0..9, bit 0 = a
    localparam logic [7:0] SEG_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic       op;
        logic [9:0] smp;
    } disp_item_t;

    typedef struct packed {
        logic [3:0] enable;
        logic [7:0] seg;
    } drive_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [13:0] full_scale_mv;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [9:0]  sample;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  digit_enable;
    logic [7:0]  segments;

    disp_item_t  pending_item_q [$];
    drive_t      expected_drive_q [$];

    // local copy of the display state
    logic [3:0]  shown_digit [NUM_DIGITS];
    logic [1:0]  lit_position;
    logic [13:0] scale_setting;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatch_count;
    int          quiet_cycles;
    logic        in_taken;

    adc_millivolt_seven_segment_display #(
        .DIGIT_COUNT (NUM_DIGITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .full_scale_mv (full_scale_mv),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digit_enable  (digit_enable),
        .segments      (segments)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Display model: a sample rewrites all digits and keeps the position,
    // a tick moves the position first. Either way the word for the
    // (possibly new) position is produced.
    // ------------------------------------------------------------------
    function automatic drive_t predict_drive(input logic op, input logic [9:0] smp);
        int unsigned scale;
        int unsigned millivolts;
        logic [3:0]  d;
        drive_t      w;
        if (op == adcmv_pkg::OP_SAMPLE)
        begin
            // settings above the four-digit range are clamped to 9999
            scale = (scale_setting > adcmv_pkg::MV_CAP) ? 32'(adcmv_pkg::MV_CAP)
                                                        : 32'(scale_setting);
            millivolts = (smp * scale) / adcmv_pkg::ADC_FULL;
            for (int k = NUM_DIGITS - 1; k >= 0; k--)
            begin
                shown_digit[k] = 4'(millivolts % 10);
                millivolts = millivolts / 10;
            end
        end
        else
        begin
            lit_position = 2'((lit_position + 1) % NUM_DIGITS);
        end
        d        = shown_digit[lit_position];
        w.enable = 4'b0001 << lit_position;
        w.seg    = (d < 10) ? SEG_GLYPH[d] : adcmv_pkg::SEG_BLANK;
        // decimal point sits on the leftmost digit
        if (lit_position == 0)
        begin
            w.seg = w.seg | adcmv_pkg::SEG_DP;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge. An offered transaction is
    // held until the rising edge that accepts it.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && !in_taken))
            begin
                if (pending_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    operation <= pending_item_q[0].op;
                    sample    <= pending_item_q[0].smp;
                    in_valid  <= 1'b1;
                    void'(pending_item_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled on the rising edge. Predictions are
    // made as input transactions are accepted, config writes update the
    // local scale, and each output transaction is checked in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        drive_t want;
        drive_t got;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                scale_setting = full_scale_mv;
            end
            if (in_valid && in_ready)
            begin
                expected_drive_q.push_back(predict_drive(operation, sample));
            end
            if (out_valid && out_ready)
            begin
                got.enable = digit_enable;
                got.seg    = segments;
                if (expected_drive_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected drive word en=%h seg=%h",
                                 $realtime, got.enable, got.seg);
                    end
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (got.enable !== want.enable || got.seg !== want.seg)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("%0t: drive mismatch en exp=%h act=%h, seg exp=%h act=%h",
                                     $realtime, want.enable, got.enable, want.seg, got.seg);
                        end
                    end
                end
            end

            // watchdog on the handshakes
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic op, input logic [9:0] smp);
        disp_item_t it;
        it.op  = op;
        it.smp = smp;
        pending_item_q.push_back(it);
    endtask

    // wait until every queued transaction has gone in and come back
    task automatic wait_drained();
        while (pending_item_q.size() != 0 || in_valid || expected_drive_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_scale(input logic [13:0] value);
        @(negedge clk);
        full_scale_mv <= value;
        cfg_valid     <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        @(posedge clk);
        case (mode)
            IDLE_SEND:
            begin
                send_idle_pct  = 58;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 58;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // random mix of samples and ticks, extremes of the sample now and then
    task automatic load_random(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                push_item(adcmv_pkg::OP_SAMPLE, 10'h3FF);
            end
            else if (pick == 1)
            begin
                push_item(adcmv_pkg::OP_SAMPLE, 10'h000);
            end
            else
            begin
                push_item(1'($urandom_range(1)), 10'($urandom_range(1023)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [13:0] scale_pick;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        full_scale_mv  = '0;
        in_valid       = 1'b0;
        operation      = adcmv_pkg::OP_SAMPLE;
        sample         = '0;
        out_ready      = 1'b0;
        in_taken       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        lit_position   = '0;
        scale_setting  = adcmv_pkg::FS_RESET;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            shown_digit[k] = '0;
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset scale first, positions walked round and wrapped
        push_item(adcmv_pkg::OP_SAMPLE, 10'd0);
        push_item(adcmv_pkg::OP_SAMPLE, 10'd1023);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        push_item(adcmv_pkg::OP_TICK,   10'h3FF);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        push_item(adcmv_pkg::OP_TICK,   10'd0);      // wraps back to the leftmost digit
        push_item(adcmv_pkg::OP_SAMPLE, 10'd1);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        push_item(adcmv_pkg::OP_SAMPLE, 10'h2AA);    // sample shown on the unchanged position
        push_item(adcmv_pkg::OP_SAMPLE, 10'h155);
        wait_drained();

        // top of the range: full scale reads 9999
        write_scale(adcmv_pkg::MV_CAP);
        push_item(adcmv_pkg::OP_SAMPLE, 10'd1023);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        wait_drained();

        // zero scale shows 0000 whatever the sample
        write_scale(14'd0);
        push_item(adcmv_pkg::OP_SAMPLE, 10'd1023);
        push_item(adcmv_pkg::OP_TICK,   10'd0);
        wait_drained();

        // setting beyond four digits behaves as 9999
        write_scale(14'h3FFF);
        push_item(adcmv_pkg::OP_SAMPLE, 10'd1023);
        push_item(adcmv_pkg::OP_SAMPLE, 10'd512);
        wait_drained();

        // random phases, idle pattern rotating, scale changed each time
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       scale_pick = adcmv_pkg::MV_CAP;
                1:       scale_pick = 14'd1;
                2:       scale_pick = 14'd0;
                3:       scale_pick = 14'h3FFF;
                4:       scale_pick = 14'($urandom_range(9999, 1));
                5:       scale_pick = 14'($urandom_range(16383));
                6:       scale_pick = 14'd1023;
                default: scale_pick = adcmv_pkg::FS_RESET;
            endcase
            write_scale(scale_pick);
            set_idling(p % 4);
            load_random(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatch_count == 0 && expected_drive_q.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/adcmv_pkg.sv
hw/rtl/adc_millivolt_seven_segment_display.sv
bench/tb.sv
